>>> hdl/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master.
`timescale 1ns / 1ps

package i2cbm_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned TPU_W     = 10;
  localparam int unsigned POLL_W    = 8;
  localparam int unsigned DLY_W     = TPU_W + 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd1;

  localparam logic [TPU_W-1:0]  TPU_RESET     = 10'd8;
  localparam logic [TPU_W-1:0]  TPU_WIDTH_ONE = 10'd1;
  localparam logic [POLL_W-1:0] POLL_RESET    = 8'd250;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_WAIT,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 send_ack;
    logic                 sda_in;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } head_t;

endpackage

>>> hdl/i2cbm_front.sv
// Front end: accepts tick beats, decodes the opcode and queues them for the engine.
`timescale 1ns / 1ps

module i2cbm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      opcode_i,
  input  logic [i2cbm_pkg::BYTE_BITS-1:0] tx_byte_i,
  input  logic                            send_ack_i,
  input  logic                            sda_in_i,
  output i2cbm_pkg::head_t                head_o,
  input  logic                            pop_i
);

  localparam int unsigned DEPTH = 2;

  i2cbm_pkg::beat_t mem_q [DEPTH];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  i2cbm_pkg::cmd_e  cmd;
  i2cbm_pkg::beat_t beat;
  logic             push;
  logic             pop;

  // unused opcodes decode to no command
  always_comb begin
    case (opcode_i)
      i2cbm_pkg::OP_START: cmd = i2cbm_pkg::CMD_START;
      i2cbm_pkg::OP_STOP:  cmd = i2cbm_pkg::CMD_STOP;
      i2cbm_pkg::OP_WRITE: cmd = i2cbm_pkg::CMD_WRITE;
      i2cbm_pkg::OP_WAIT:  cmd = i2cbm_pkg::CMD_WAIT;
      i2cbm_pkg::OP_READ:  cmd = i2cbm_pkg::CMD_READ;
      default:             cmd = i2cbm_pkg::CMD_NONE;
    endcase
  end

  assign beat.cmd      = cmd;
  assign beat.tx_byte  = tx_byte_i;
  assign beat.send_ack = send_ack_i;
  assign beat.sda_in   = sda_in_i;

  assign in_ready_o  = (cnt_q != 2'(DEPTH));
  assign push        = in_valid_i & in_ready_o;
  assign pop         = pop_i & (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.beat  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hdl/i2cbm_engine.sv
// Back end: SCL/SDA bit sequencer with delay counter, ack polling and result register.
`timescale 1ns / 1ps

module i2cbm_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [i2cbm_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  input  i2cbm_pkg::head_t                   head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               scl_level_o,
  output logic                               sda_drive_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [i2cbm_pkg::BYTE_BITS-1:0]    rx_byte_o,
  output logic                               ack_failed_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_A1, PH_A2, PH_A3,
    PH_W1, PH_W2, PH_W3, PH_R1, PH_R2, PH_K1, PH_K2
  } phase_e;

  localparam int unsigned BW = i2cbm_pkg::BYTE_BITS;
  localparam int unsigned DW = i2cbm_pkg::DLY_W;

  phase_e                          phase_q, phase_d;
  logic [3:0]                      bit_q, bit_d;
  logic [BW-1:0]                   shift_q, shift_d;
  logic [DW-1:0]                   dly_q, dly_d;
  logic [i2cbm_pkg::POLL_W-1:0]    poll_q, poll_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            ack_q, ack_d;
  logic                            fail_q, fail_d;
  logic [BW-1:0]                   rx_q, rx_d;
  logic                            done;
  logic                            ovalid_q, ovalid_d;
  logic                            obusy_q, odone_q;
  logic [i2cbm_pkg::TPU_W-1:0]     tpu_q;
  logic [i2cbm_pkg::POLL_W-1:0]    limit_q;
  logic [i2cbm_pkg::TPU_W-1:0]     t;
  logic [DW-1:0]                   unit1, unit2, unit4;
  i2cbm_pkg::beat_t                b;

  assign b     = head_i.beat;
  assign pop_o = head_i.valid & (~ovalid_q | out_ready_i);

  // a zero tick count acts as one tick
  assign t     = (tpu_q == '0) ? i2cbm_pkg::TPU_WIDTH_ONE : tpu_q;
  assign unit1 = {2'b00, t};
  assign unit2 = {1'b0, t, 1'b0};
  assign unit4 = {t, 2'b00};

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    dly_d   = dly_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    fail_d  = fail_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (pop_o) begin
      case (phase_q)
        PH_IDLE: begin
          if (b.cmd != i2cbm_pkg::CMD_NONE) begin
            fail_d = 1'b0;
            bit_d  = '0;
            poll_d = '0;
          end
          case (b.cmd)
            i2cbm_pkg::CMD_START: begin
              sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_S1; dly_d = unit4;
            end
            i2cbm_pkg::CMD_STOP: begin
              sda_d = 1'b0; scl_d = 1'b0; phase_d = PH_P1; dly_d = unit4;
            end
            i2cbm_pkg::CMD_WRITE: begin
              scl_d   = 1'b0;
              sda_d   = b.tx_byte[BW-1];
              shift_d = {b.tx_byte[BW-2:0], 1'b0};
              phase_d = PH_W1;
              dly_d   = unit2;
            end
            i2cbm_pkg::CMD_WAIT: begin
              sda_d = 1'b1; phase_d = PH_A1; dly_d = unit1;
            end
            i2cbm_pkg::CMD_READ: begin
              ack_d   = b.send_ack;
              shift_d = '0;
              sda_d   = 1'b1;
              scl_d   = 1'b0;
              phase_d = PH_R1;
              dly_d   = unit2;
            end
            default: ;
          endcase
        end
        PH_A3: begin
          if (!b.sda_in) begin
            scl_d   = 1'b0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else if (poll_q >= limit_q) begin
            // acknowledge timed out: flag it and run a stop
            fail_d  = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_P1;
            dly_d   = unit4;
          end else begin
            poll_d = poll_q + 1'b1;
          end
        end
        default: begin
          if (dly_q > DW'(1)) begin
            dly_d = dly_q - 1'b1;
          end else begin
            case (phase_q)
              PH_S1: begin sda_d = 1'b0; phase_d = PH_S2; dly_d = unit4; end
              PH_S2: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
              PH_P1: begin
                scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_P2; dly_d = unit4;
              end
              PH_P2: begin phase_d = PH_IDLE; done = 1'b1; end
              PH_A1: begin scl_d = 1'b1; phase_d = PH_A2; dly_d = unit1; end
              PH_A2: begin phase_d = PH_A3; poll_d = '0; end
              PH_W1: begin scl_d = 1'b1; phase_d = PH_W2; dly_d = unit2; end
              PH_W2: begin scl_d = 1'b0; phase_d = PH_W3; dly_d = unit2; end
              PH_W3: begin
                bit_d = bit_q + 1'b1;
                if (bit_d >= 4'(BW)) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  sda_d   = shift_q[BW-1];
                  shift_d = {shift_q[BW-2:0], 1'b0};
                  phase_d = PH_W1;
                  dly_d   = unit2;
                end
              end
              PH_R1: begin
                scl_d   = 1'b1;
                shift_d = {shift_q[BW-2:0], b.sda_in};
                phase_d = PH_R2;
                dly_d   = unit1;
              end
              PH_R2: begin
                bit_d = bit_q + 1'b1;
                scl_d = 1'b0;
                if (bit_d >= 4'(BW)) begin
                  rx_d    = shift_q;
                  sda_d   = ~ack_q;
                  phase_d = PH_K1;
                end else begin
                  phase_d = PH_R1;
                end
                dly_d = unit2;
              end
              PH_K1: begin scl_d = 1'b1; phase_d = PH_K2; dly_d = unit2; end
              PH_K2: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      endcase
    end
    // hold the result until it is taken
    if (pop_o) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bit_q    <= '0;
      shift_q  <= '0;
      dly_q    <= '0;
      poll_q   <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b0;
      fail_q   <= 1'b0;
      rx_q     <= '0;
      ovalid_q <= 1'b0;
      obusy_q  <= 1'b0;
      odone_q  <= 1'b0;
      tpu_q    <= i2cbm_pkg::TPU_RESET;
      limit_q  <= i2cbm_pkg::POLL_RESET;
    end else begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      dly_q    <= dly_d;
      poll_q   <= poll_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      fail_q   <= fail_d;
      rx_q     <= rx_d;
      ovalid_q <= ovalid_d;
      if (pop_o) begin
        obusy_q <= (phase_d != PH_IDLE);
        odone_q <= done;
      end
      if (cfg_we_i && cfg_idx_i == i2cbm_pkg::CFG_TICKS_PER_UNIT) begin
        tpu_q <= cfg_wdata_i[i2cbm_pkg::TPU_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == i2cbm_pkg::CFG_ACK_POLL_LIMIT) begin
        limit_q <= cfg_wdata_i[i2cbm_pkg::POLL_W-1:0];
      end
    end
  end

  // line and byte state only moves on a pop, so it doubles as the result payload
  assign out_valid_o  = ovalid_q;
  assign scl_level_o  = scl_q;
  assign sda_drive_o  = sda_q;
  assign busy_res_o   = obusy_q;
  assign done_res_o   = odone_q;
  assign rx_byte_o    = rx_q;
  assign ack_failed_o = fail_q;

endmodule

>>> hdl/i2c_bit_level_master.sv
// Top level of the tick-driven I2C bit-level master.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o | opcode_i, tx_byte_i, send_ack_i, sda_in_i
//  out      | out_valid_o/out_ready_i | scl_level_o, sda_drive_o, busy_res_o,
//           |                         | done_res_o, rx_byte_o, ack_failed_o
//  cfg      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One tick beat is taken per cycle while in_ready_o is high; each beat is queued and
// then its result is registered. Throughput is one beat per cycle while out is not stalled.
// A two-entry queue parts the decode front from the sequencer; the result register
// keeps popping while the consumer takes results, and a stalled output backs up into
// the queue and then into in_ready_o. Reset puts SCL and SDA released and the engine idle.
`timescale 1ns / 1ps

module i2c_bit_level_master (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [i2cbm_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         opcode_i,
  input  logic [i2cbm_pkg::BYTE_BITS-1:0]    tx_byte_i,
  input  logic                               send_ack_i,
  input  logic                               sda_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               scl_level_o,
  output logic                               sda_drive_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [i2cbm_pkg::BYTE_BITS-1:0]    rx_byte_o,
  output logic                               ack_failed_o
);

  i2cbm_pkg::head_t head;
  logic             pop;

  i2cbm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .tx_byte_i  (tx_byte_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  i2cbm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rx_byte_o    (rx_byte_o),
    .ack_failed_o (ack_failed_o)
  );

endmodule
